>>> hdl/bcfm_pkg.sv
package bcfm_pkg;

  localparam int CELLS_PER_CHIP = 12;
  localparam int MASK_W         = 12;

  typedef enum logic [1:0] {
    MODE_CELL = 2'd0,
    MODE_TEMP = 2'd1,
    MODE_END  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CLS_OK   = 3'd0,
    CLS_OV   = 3'd1,
    CLS_UV   = 3'd2,
    CLS_SOFT = 3'd3,
    CLS_HOT  = 3'd4,
    CLS_COLD = 3'd5,
    CLS_SKIP = 3'd6
  } class_t;

  typedef enum logic [2:0] {
    CFG_OV_LIMIT   = 3'd0,
    CFG_UV_LIMIT   = 3'd1,
    CFG_HOT_LIMIT  = 3'd2,
    CFG_SOFT_LIMIT = 3'd3,
    CFG_COLD_LIMIT = 3'd4,
    CFG_FAIL_LIMIT = 3'd5,
    CFG_CELL_MASK  = 3'd6
  } cfg_idx_t;

  localparam int FLAG_UV   = 0;
  localparam int FLAG_OV   = 1;
  localparam int FLAG_COLD = 2;
  localparam int FLAG_HOT  = 3;
  localparam int FLAG_SOFT = 4;

  localparam logic [4:0] VOLT_MASK = 5'b00011;
  localparam logic [4:0] TEMP_MASK = 5'b11100;
  localparam logic [4:0] HARD_MASK = 5'b01111;

  localparam logic [15:0]       OV_RESET   = 16'd42000;
  localparam logic [15:0]       UV_RESET   = 16'd30000;
  localparam logic [15:0]       HOT_RESET  = 16'd728;
  localparam logic [15:0]       SOFT_RESET = 16'd1255;
  localparam logic [15:0]       COLD_RESET = 16'd7384;
  localparam logic [7:0]        FAIL_RESET = 8'd3;
  localparam logic [MASK_W-1:0] MASK_RESET = 12'd3120;

  typedef struct packed {
    logic [15:0]       ov_limit;
    logic [15:0]       uv_limit;
    logic [15:0]       hot_limit;
    logic [15:0]       soft_limit;
    logic [15:0]       cold_limit;
    logic [7:0]        fail_limit;
    logic [MASK_W-1:0] cell_mask;
  } cfg_t;

  typedef struct packed {
    logic [4:0] pending;
    logic [4:0] committed;
    logic [7:0] fail_count;
    logic       relay;
    logic       first_done;
  } mon_state_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] code;
    logic [3:0]  pos;
    logic        vfail;
    logic        tfail;
  } sample_t;

endpackage

>>> hdl/bcfm_eval.sv
module bcfm_eval (
  input  bcfm_pkg::sample_t    smp,
  input  bcfm_pkg::cfg_t       cfg,
  input  bcfm_pkg::mon_state_t st,
  output bcfm_pkg::mon_state_t st_next,
  output bcfm_pkg::class_t     cls
);
  import bcfm_pkg::*;

  logic       masked;
  logic [4:0] committed;
  logic [7:0] count;

  always_comb begin
    masked = 1'b0;
    if ({1'b0, smp.pos} >= 5'(CELLS_PER_CHIP)) begin
      masked = 1'b1;
    end else if ({1'b0, smp.pos} < 5'(MASK_W)) begin
      masked = cfg.cell_mask[smp.pos];
    end
  end

  always_comb begin
    st_next   = st;
    cls       = CLS_OK;
    committed = st.committed;
    count     = st.fail_count;
    unique case (smp.mode)
      MODE_CELL: begin
        if (masked) begin
          cls = CLS_SKIP;
        end else if (smp.code > cfg.ov_limit) begin
          cls = CLS_OV;
          st_next.pending[FLAG_OV] = 1'b1;
        end else if (smp.code < cfg.uv_limit) begin
          cls = CLS_UV;
          st_next.pending[FLAG_UV] = 1'b1;
        end
      end
      MODE_TEMP: begin
        if (smp.code < cfg.hot_limit) begin
          cls = CLS_HOT;
          st_next.pending[FLAG_HOT] = 1'b1;
        end else if (smp.code < cfg.soft_limit) begin
          cls = CLS_SOFT;
          st_next.pending[FLAG_SOFT] = 1'b1;
        end else if (smp.code > cfg.cold_limit) begin
          cls = CLS_COLD;
          st_next.pending[FLAG_COLD] = 1'b1;
        end
      end
      MODE_END: begin
        if (!smp.vfail) begin
          committed = (committed & ~VOLT_MASK) | (st.pending & VOLT_MASK);
        end
        if (!smp.tfail) begin
          committed = (committed & ~TEMP_MASK) | (st.pending & TEMP_MASK);
        end
        st_next.committed = committed;
        st_next.pending   = '0;
        if (!st.first_done) begin
          st_next.first_done = 1'b1;
          st_next.relay      = ~|(committed & HARD_MASK);
        end else begin
          if (smp.vfail || smp.tfail) begin
            if (count < cfg.fail_limit) begin
              count = count + 8'd1;
            end
          end else begin
            count = '0;
          end
          st_next.fail_count = count;
          if (|(committed & HARD_MASK) || count >= cfg.fail_limit) begin
            st_next.relay = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/battery_cell_fault_monitor_core.sv
// Accepted samples pass the input register, then the result register, onto m_tdata.
// Throughput: one sample per clock unless m_tready stalls; the input register feeds
// one compare pass into the result register, and the state advances with each result.
// Reset (rst, synchronous): flags, failed-scan count and first-scan mark clear,
// relay open, limits and cell mask return to their defaults, both stages empty.
module battery_cell_fault_monitor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // sample_code, cell_position, voltage_read_failed,
                                 // temp_read_failed, 2 bits zero
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // sample_class, fault_flags, failed_scans,
                                 // relay_closed, 7 bits zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bcfm_pkg::*;

  logic       in_valid;
  sample_t    in_smp;
  logic       out_valid;
  class_t     out_cls;
  mon_state_t st;
  mon_state_t st_next;
  class_t     cls;
  cfg_t       cfg;
  logic       advance;

  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  bcfm_eval u_eval (
    .smp     (in_smp),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .cls     (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_smp.mode  <= mode_t'(s_tuser);
      in_smp.code  <= s_tdata[15:0];
      in_smp.pos   <= s_tdata[19:16];
      in_smp.vfail <= s_tdata[20];
      in_smp.tfail <= s_tdata[21];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      st        <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_cls <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ov_limit   <= OV_RESET;
      cfg.uv_limit   <= UV_RESET;
      cfg.hot_limit  <= HOT_RESET;
      cfg.soft_limit <= SOFT_RESET;
      cfg.cold_limit <= COLD_RESET;
      cfg.fail_limit <= FAIL_RESET;
      cfg.cell_mask  <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OV_LIMIT:   cfg.ov_limit   <= cfg_data;
        CFG_UV_LIMIT:   cfg.uv_limit   <= cfg_data;
        CFG_HOT_LIMIT:  cfg.hot_limit  <= cfg_data;
        CFG_SOFT_LIMIT: cfg.soft_limit <= cfg_data;
        CFG_COLD_LIMIT: cfg.cold_limit <= cfg_data;
        CFG_FAIL_LIMIT: cfg.fail_limit <= cfg_data[7:0];
        CFG_CELL_MASK:  cfg.cell_mask  <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, st.relay, st.fail_count, st.committed, out_cls};

  // relay can only close on the first end of scan
  assert property (@(posedge clk) disable iff (rst)
    $rose(st.relay) |-> !$past(st.first_done))
    else $error("relay closed after first scan");

  // every processed end of scan leaves no pending flags
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid && in_smp.mode == MODE_END) |=> (st.pending == '0))
    else $error("pending flags survived end of scan");

  // failed-scan count only moves once the first scan is done
  assert property (@(posedge clk) disable iff (rst)
    (st.fail_count != '0) |-> st.first_done)
    else $error("failed-scan count before first scan");

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcfm_pkg::*;

  class cell_monitor_sb;
    cfg_t        lim;
    mon_state_t  st;
    logic [23:0] status_due[$];
    int          mismatches;
    int          noted;
    int          scans;
    int          checked;
    int          relay_closed_seen;
    int          peak_count;
    logic [6:0]  classes_seen;

    function new();
      lim = '{OV_RESET, UV_RESET, HOT_RESET, SOFT_RESET, COLD_RESET, FAIL_RESET, MASK_RESET};
      st = '0;
      mismatches = 0;
      noted = 0;
      scans = 0;
      checked = 0;
      relay_closed_seen = 0;
      peak_count = 0;
      classes_seen = '0;
    endfunction

    function void apply_limit(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_OV_LIMIT:   lim.ov_limit = val;
        CFG_UV_LIMIT:   lim.uv_limit = val;
        CFG_HOT_LIMIT:  lim.hot_limit = val;
        CFG_SOFT_LIMIT: lim.soft_limit = val;
        CFG_COLD_LIMIT: lim.cold_limit = val;
        CFG_FAIL_LIMIT: lim.fail_limit = val[7:0];
        CFG_CELL_MASK:  lim.cell_mask = val[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // predicts the status word for one accepted sample
    function void note_sample(sample_t s);
      class_t cls;
      cls = CLS_OK;
      case (s.mode)
        MODE_CELL: begin
          if (s.pos >= CELLS_PER_CHIP) begin
            cls = CLS_SKIP;
          end else if (lim.cell_mask[s.pos]) begin
            cls = CLS_SKIP;
          end else if (s.code > lim.ov_limit) begin
            cls = CLS_OV;
            st.pending[FLAG_OV] = 1'b1;
          end else if (s.code < lim.uv_limit) begin
            cls = CLS_UV;
            st.pending[FLAG_UV] = 1'b1;
          end
        end
        MODE_TEMP: begin
          // hard hot wins over soft hot
          if (s.code < lim.hot_limit) begin
            cls = CLS_HOT;
            st.pending[FLAG_HOT] = 1'b1;
          end else if (s.code < lim.soft_limit) begin
            cls = CLS_SOFT;
            st.pending[FLAG_SOFT] = 1'b1;
          end else if (s.code > lim.cold_limit) begin
            cls = CLS_COLD;
            st.pending[FLAG_COLD] = 1'b1;
          end
        end
        MODE_END: begin
          scans++;
          if (!s.vfail) st.committed = (st.committed & ~VOLT_MASK) | (st.pending & VOLT_MASK);
          if (!s.tfail) st.committed = (st.committed & ~TEMP_MASK) | (st.pending & TEMP_MASK);
          st.pending = '0;
          if (!st.first_done) begin
            st.first_done = 1'b1;
            st.relay = ~|(st.committed & HARD_MASK);
          end else begin
            if (s.vfail || s.tfail) begin
              if (st.fail_count < lim.fail_limit && st.fail_count != 8'hFF)
                st.fail_count = st.fail_count + 8'd1;
            end else begin
              st.fail_count = '0;
            end
            if (|(st.committed & HARD_MASK) || st.fail_count >= lim.fail_limit)
              st.relay = 1'b0;
          end
        end
        default: ;
      endcase
      noted++;
      classes_seen[cls] = 1'b1;
      if (st.relay) relay_closed_seen++;
      if (st.fail_count > peak_count) peak_count = st.fail_count;
      status_due.push_back({7'd0, st.relay, st.fail_count, st.committed, cls});
    endfunction

    function void check_result(logic [23:0] got);
      logic [23:0] want;
      checked++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %h arrived with no sample outstanding", got);
        return;
      end
      want = status_due.pop_front();
      if (got[2:0] !== want[2:0] || got[7:3] !== want[7:3] ||
          got[15:8] !== want[15:8] || got[16] !== want[16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: want class %0d flags %b count %0d relay %b, ",
                    "got class %0d flags %b count %0d relay %b"},
                   want[2:0], want[7:3], want[15:8], want[16],
                   got[2:0], got[7:3], got[15:8], got[16]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // sample_code, cell_position, voltage_read_failed, temp_read_failed
  logic [1:0]  s_tuser;   // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // sample_class, fault_flags, failed_scans, relay_closed
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  logic idle_on;
  logic hold_req;

  cell_monitor_sb sb = new();

  battery_cell_fault_monitor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 150;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("timeout with %0d status words outstanding", sb.status_due.size());
    $display("battery_cell_fault_monitor_core test failed");
    $finish;
  end

  task automatic send_item(input mode_t m, input logic [15:0] code, input logic [3:0] pos,
                           input logic vf, input logic tf);
    sample_t s;
    s = '{mode: m, code: code, pos: pos, vfail: vf, tfail: tf};
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= {2'b00, tf, vf, pos, code};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(s);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_limits(input logic [15:0] ov, input logic [15:0] uv,
                             input logic [15:0] hot, input logic [15:0] soft_lim,
                             input logic [15:0] cold, input logic [7:0] fl,
                             input logic [11:0] mask);
    cfg_idx_t    idx_list[7];
    logic [15:0] val_list[7];
    idx_list = '{CFG_OV_LIMIT, CFG_UV_LIMIT, CFG_HOT_LIMIT, CFG_SOFT_LIMIT,
                 CFG_COLD_LIMIT, CFG_FAIL_LIMIT, CFG_CELL_MASK};
    val_list = '{ov, uv, hot, soft_lim, cold, {8'd0, fl}, {4'd0, mask}};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
      sb.apply_limit(idx_list[i], val_list[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // well-formed scans with codes around the limits, mixed with stray transactions
  task automatic run_scans(input int n_items, input int fail_pct, input int max_len,
                           input int noise_pct);
    int          sent;
    int          len;
    mode_t       m;
    logic [15:0] base;
    logic [15:0] code;
    logic [3:0]  pos;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(mode_t'($urandom_range(0, 3)), 16'($urandom), 4'($urandom),
                  1'($urandom), 1'($urandom));
        sent++;
      end else begin
        len = $urandom_range(0, max_len);
        repeat (len) begin
          m = ($urandom_range(0, 2) == 0) ? MODE_TEMP : MODE_CELL;
          if (m == MODE_CELL) begin
            base = $urandom_range(0, 1) ? sb.lim.ov_limit : sb.lim.uv_limit;
          end else begin
            case ($urandom_range(0, 2))
              0: base = sb.lim.hot_limit;
              1: base = sb.lim.soft_limit;
              default: base = sb.lim.cold_limit;
            endcase
          end
          case ($urandom_range(0, 4))
            0: code = 16'($urandom);
            1: code = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: code = base + 16'($urandom_range(0, 2)) - 16'd1;
          endcase
          pos = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                            : 4'($urandom_range(0, 11));
          send_item(m, code, pos, 1'($urandom), 1'($urandom));
        end
        send_item(MODE_END, 16'($urandom), 4'($urandom),
                  $urandom_range(0, 99) < fail_pct, $urandom_range(0, 99) < fail_pct);
        sent += len + 1;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = MODE_CELL;
    cfg_valid = 1'b0;
    cfg_index = CFG_OV_LIMIT;
    cfg_data  = '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first scan: clean apart from soft hot, so the relay closes
    send_item(MODE_CELL, 16'd42000, 4'd0, 1'b0, 1'b0);
    send_item(MODE_CELL, 16'd30000, 4'd1, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'd1254, 4'd0, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'd7384, 4'd0, 1'b0, 1'b0);
    send_item(MODE_CELL, 16'hFFFF, 4'd4, 1'b0, 1'b0);
    send_item(MODE_CELL, 16'h0000, 4'd12, 1'b0, 1'b0);
    send_item(MODE_NONE, 16'hFFFF, 4'd15, 1'b1, 1'b1);
    send_item(MODE_END, 16'h0000, 4'd0, 1'b0, 1'b0);
    // hard faults lost to two failed reads
    send_item(MODE_CELL, 16'd42001, 4'd1, 1'b0, 1'b0);
    send_item(MODE_CELL, 16'h0000, 4'd3, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'd727, 4'd15, 1'b1, 1'b1);
    send_item(MODE_CELL, 16'd12345, 4'd15, 1'b1, 1'b0);
    send_item(MODE_END, 16'hFFFF, 4'd15, 1'b1, 1'b1);
    // cold commits, relay opens
    send_item(MODE_TEMP, 16'hFFFF, 4'd0, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'd7385, 4'd0, 1'b0, 1'b0);
    send_item(MODE_END, 16'h0000, 4'd0, 1'b1, 1'b0);
    // undervoltage flag commits, count reaches its limit
    send_item(MODE_CELL, 16'd29999, 4'd2, 1'b0, 1'b0);
    send_item(MODE_CELL, 16'hFFFF, 4'd11, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'd1255, 4'd0, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'd728, 4'd0, 1'b0, 1'b0);
    send_item(MODE_TEMP, 16'h0000, 4'd0, 1'b0, 1'b0);
    send_item(MODE_END, 16'h0000, 4'd0, 1'b0, 1'b1);
    send_item(MODE_END, 16'h0000, 4'd0, 1'b1, 1'b1);
    settle();

    load_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                8'($urandom_range(1, 6)), 12'($urandom));
    run_scans(200, 25, 12, 8);
    settle();

    load_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1, 12'h000);
    run_scans(120, 30, 10, 8);
    settle();

    // failed-scan count runs up to 255 and saturates
    load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 12'hFFF);
    run_scans(300, 100, 0, 0);
    settle();

    load_limits(16'd42000, 16'd30000, 16'd728, 16'd1255, 16'd7384, 8'd3, 12'd3120);
    hold_req = 1'b1;
    run_scans(150, 25, 12, 8);
    settle();

    idle_on = 1'b0;
    load_limits(16'($urandom_range(20000, 65535)), 16'($urandom_range(0, 40000)),
                16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)),
                16'($urandom), 8'($urandom_range(1, 255)), 12'($urandom));
    run_scans(150, 25, 12, 8);
    settle();
    repeat (10) @(posedge clk);

    $display("%0d samples in %0d scans over six limit settings, %0d status words checked",
             sb.noted, sb.scans, sb.checked);
    $display("classes seen %b, relay closed in %0d results, peak failed-scan count %0d",
             sb.classes_seen, sb.relay_closed_seen, sb.peak_count);
    if (sb.mismatches == 0 && sb.status_due.size() == 0) begin
      $display("battery_cell_fault_monitor_core test passed");
    end else begin
      $display("%0d mismatches, %0d status words outstanding",
               sb.mismatches, sb.status_due.size());
      $display("battery_cell_fault_monitor_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bcfm_pkg.sv
hdl/bcfm_eval.sv
hdl/battery_cell_fault_monitor_core.sv
verif/tb.sv
